// ===== rtl/wwmf_pkg.sv =====
// Package with shared constants, types and codes of the wrapped window median filter.
package wwmf_pkg;

    localparam int DIM_BITS   = 8;
    localparam int MAX_DIM    = 256;
    localparam int ADDR_BITS  = 2 * DIM_BITS;
    localparam int PIX_BITS   = 8;
    localparam int MAX_KERNEL = 7;
    localparam int WIN_CAP    = MAX_KERNEL * MAX_KERNEL;
    localparam int CNT_BITS   = $clog2(WIN_CAP + 1);
    localparam int KS_BITS    = 3;
    localparam int DIMREG_BITS = 9;
    localparam int CFG_BITS   = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int SH_BITS    = $clog2(DIM_BITS);

    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd2;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef logic [PIX_BITS-1:0] t_pixel;

    // Control of the sorting cell row.
    typedef struct packed {
        logic   clear;
        logic   insert;
        t_pixel value;
    } t_sort_ctrl;

endpackage

// ===== rtl/wwmf_ram.sv =====
// Generic single port RAM with registered read.
module wwmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/wwmf_sort_cell.sv =====
// One cell of the insertion sorting row; keeps the cells ascending.
module wwmf_sort_cell
    import wwmf_pkg::*;
(
    input  logic       i_clk,
    input  t_sort_ctrl i_ctrl,
    input  t_pixel     i_left_value,
    input  logic       i_left_full,
    input  logic       i_left_shift,
    output t_pixel     o_value,
    output logic       o_full,
    output logic       o_shift
);
    t_pixel r_value;
    logic   r_full;
    logic   n_take;

    // A cell shifts right when it holds a value greater than the new one.
    assign o_shift = r_full && (r_value > i_ctrl.value);
    assign n_take  = !r_full && i_left_full;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_full <= 1'b0;
        end else if (i_ctrl.insert) begin
            if (i_left_shift) begin
                r_value <= i_left_value;
                r_full  <= 1'b1;
            end else if (o_shift) begin
                r_value <= i_ctrl.value;
            end else if (n_take) begin
                r_value <= i_ctrl.value;
                r_full  <= 1'b1;
            end
        end
    end

    assign o_value = r_value;
    assign o_full  = r_full;
endmodule

// ===== rtl/wrapped_window_median_filter.sv =====
// Top level of the wrapped window median filter.
//
// Channel   Direction  Signals
// request   in         i_valid, o_stall, i_action, i_row, i_column, i_pixel_value
// result    out        o_valid, i_stall, o_median_value
// config    in         i_cfg_we, i_cfg_index, i_cfg_data
//
// A write request never stalls the input.
// A compute request presents its result after these steps in order: the row and column are
// reduced modulo the image, the window corner is found, the window is read into the sorting
// cell row, the last pixel is let settle, and the median is formed.
// The input stays stalled until the result is taken; a new request can be taken in the next cycle.
// Reset is synchronous and active low; the image memory is not cleared.
module wrapped_window_median_filter
    import wwmf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_action,
    input  logic [DIM_BITS-1:0]     i_row,
    input  logic [DIM_BITS-1:0]     i_column,
    input  logic [PIX_BITS-1:0]     i_pixel_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PIX_BITS-1:0]     o_median_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] RED_MOD  = 2'd0;
    localparam logic [1:0] RED_BACK = 2'd1;
    localparam logic [1:0] RED_DONE = 2'd3;

    logic [1:0]            r_state;
    logic [KS_BITS-1:0]    r_k;
    logic [DIMREG_BITS-1:0] r_h;
    logic [DIMREG_BITS-1:0] r_w;
    logic [DIM_BITS-1:0]   r_r;
    logic [DIM_BITS-1:0]   r_c;
    logic [DIM_BITS-1:0]   r_left;
    logic [KS_BITS-1:0]    r_b;
    logic [CNT_BITS-1:0]   r_issued;
    logic [CNT_BITS-1:0]   r_n;
    logic                  r_rd_vld;
    logic [DIM_BITS-1:0]   r_rowm;
    logic [DIM_BITS-1:0]   r_colm;
    logic [SH_BITS-1:0]    r_sh;
    logic [1:0]            r_red;
    logic                  r_out_vld;
    t_pixel                r_med;

    logic                  n_accept;
    logic                  n_ram_we;
    logic [ADDR_BITS-1:0]  n_addr;
    t_pixel                n_rdata;
    t_sort_ctrl            n_ctrl;
    t_pixel                n_val   [WIN_CAP+1];
    logic                  n_full  [WIN_CAP+1];
    logic                  n_shift [WIN_CAP+1];
    logic [DIM_BITS-1:0]   n_rnext;
    logic [DIM_BITS-1:0]   n_cnext;
    logic [ADDR_BITS-1:0]  n_hsh;
    logic [ADDR_BITS-1:0]  n_wsh;
    logic [CNT_BITS-1:0]   n_half;
    logic [PIX_BITS:0]     n_sum;
    t_pixel                n_lo;
    t_pixel                n_hi;

    function automatic logic [KS_BITS-1:0] clamp_k(input logic [KS_BITS-1:0] v);
        return (v == '0) ? KS_BITS'(1) : v;
    endfunction

    function automatic logic [DIMREG_BITS-1:0] clamp_d(input logic [DIMREG_BITS-1:0] v);
        logic [DIMREG_BITS-1:0] res;
        res = v;
        if (v == '0) res = DIMREG_BITS'(1);
        if (v > DIMREG_BITS'(MAX_DIM)) res = DIMREG_BITS'(MAX_DIM);
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= KS_BITS'(3);
            r_h <= DIMREG_BITS'(MAX_DIM);
            r_w <= DIMREG_BITS'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KERNEL_SIZE:  r_k <= clamp_k(i_cfg_data[KS_BITS-1:0]);
                CFG_IMAGE_HEIGHT: r_h <= clamp_d(i_cfg_data);
                CFG_IMAGE_WIDTH:  r_w <= clamp_d(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign n_accept = i_valid && !o_stall;
    assign n_ram_we = n_accept && (i_action == ACT_WRITE);

    // Wrapping steps: +1 modulo the dimension, one compare that wraps to zero.
    assign n_rnext = ({1'b0, r_r} + (DIM_BITS+1)'(1) >= r_h) ? '0 : r_r + DIM_BITS'(1);
    assign n_cnext = ({1'b0, r_c} + (DIM_BITS+1)'(1) >= r_w) ? '0 : r_c + DIM_BITS'(1);

    // Shifted dimensions for the remainder steps.
    assign n_hsh = ADDR_BITS'(r_h) << r_sh;
    assign n_wsh = ADDR_BITS'(r_w) << r_sh;

    assign n_addr = n_ram_we ? {i_row, i_column} : {r_r, r_c};

    wwmf_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_DIM * MAX_DIM)) u_image (
        .i_clk  (i_clk),
        .i_we   (n_ram_we),
        .i_addr (n_addr),
        .i_wdata(i_pixel_value),
        .o_rdata(n_rdata)
    );

    assign n_ctrl.clear  = n_accept;
    assign n_ctrl.insert = r_rd_vld;
    assign n_ctrl.value  = n_rdata;

    assign n_val[0]   = '0;
    assign n_full[0]  = 1'b1;
    assign n_shift[0] = 1'b0;

    for (genvar g = 0; g < WIN_CAP; g++) begin : g_cell
        wwmf_sort_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (n_ctrl),
            .i_left_value(n_val[g]),
            .i_left_full (n_full[g]),
            .i_left_shift(n_shift[g]),
            .o_value     (n_val[g+1]),
            .o_full      (n_full[g+1]),
            .o_shift     (n_shift[g+1])
        );
    end

    always_comb begin
        n_half = r_n >> 1;
        n_hi   = '0;
        n_lo   = '0;
        for (int i = 0; i < WIN_CAP; i++) begin
            if (CNT_BITS'(i) == n_half) n_hi = n_val[i+1];
            if (CNT_BITS'(i + 1) == n_half) n_lo = n_val[i+1];
        end
        n_sum = {1'b0, n_lo} + {1'b0, n_hi};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_red     <= RED_MOD;
        end else begin
            r_rd_vld  <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (n_accept && i_action == ACT_COMPUTE) begin
                        r_rowm   <= i_row;
                        r_colm   <= i_column;
                        r_sh     <= SH_BITS'(DIM_BITS - 1);
                        r_red    <= RED_MOD;
                        r_n      <= CNT_BITS'(r_k) * CNT_BITS'(r_k);
                        r_issued <= '0;
                        r_b      <= '0;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_red != RED_DONE) begin
                        // Reduce the request modulo the image, then step back one.
                        if (r_red == RED_MOD) begin
                            if ({DIM_BITS'(0), r_rowm} >= n_hsh)
                                r_rowm <= r_rowm - n_hsh[DIM_BITS-1:0];
                            if ({DIM_BITS'(0), r_colm} >= n_wsh)
                                r_colm <= r_colm - n_wsh[DIM_BITS-1:0];
                            if (r_sh == '0) r_red <= RED_BACK;
                            else r_sh <= r_sh - SH_BITS'(1);
                        end else begin
                            r_r    <= (r_rowm == '0) ? DIM_BITS'(r_h - DIMREG_BITS'(1))
                                                     : r_rowm - DIM_BITS'(1);
                            r_left <= (r_colm == '0) ? DIM_BITS'(r_w - DIMREG_BITS'(1))
                                                     : r_colm - DIM_BITS'(1);
                            r_c    <= (r_colm == '0) ? DIM_BITS'(r_w - DIMREG_BITS'(1))
                                                     : r_colm - DIM_BITS'(1);
                            r_red  <= RED_DONE;
                        end
                    end else if (r_issued == r_n) begin
                        if (!r_rd_vld) r_state <= ST_DONE;
                    end else begin
                        r_rd_vld <= 1'b1;
                        r_issued <= r_issued + CNT_BITS'(1);
                        if (r_b == r_k - KS_BITS'(1)) begin
                            r_b <= '0;
                            r_c <= r_left;
                            r_r <= n_rnext;
                        end else begin
                            r_b <= r_b + KS_BITS'(1);
                            r_c <= n_cnext;
                        end
                    end
                end
                ST_DONE: begin
                    r_med     <= r_n[0] ? n_hi : n_sum[PIX_BITS:1];
                    r_out_vld <= 1'b1;
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_out_vld <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_median_value = r_med;

    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_OUT))
        else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !n_accept)
        else $error("request accepted while busy");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_issued <= r_n))
        else $error("too many window reads");
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_valid)
        else $error("median not presented");
endmodule

// ===== tb/tb_wrapped_window_median_filter.sv =====
// Testbench for the wrapped window median filter: pixel writes and median requests driven, medians checked.
module tb_wrapped_window_median_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import wwmf_pkg::*;

    localparam int LIMIT = 1000000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAD_INDEX = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_action = ACT_WRITE;
    logic [DIM_BITS-1:0]     i_row = '0;
    logic [DIM_BITS-1:0]     i_column = '0;
    logic [PIX_BITS-1:0]     i_pixel_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [PIX_BITS-1:0]     o_median_value;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_KERNEL_SIZE;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    wrapped_window_median_filter dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow of the image store and the filter settings.
    t_pixel   img_mem   [MAX_DIM*MAX_DIM];
    bit       img_known [MAX_DIM*MAX_DIM];
    int       kern, hgt, wid;
    t_pixel   medians_due[$];
    int       errors, n_cycles, n_checked, n_writes, n_computes;
    bit       quiet, hold_req;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int win_addr(int r, int c, int a, int b);
        int top, left;
        top  = ((r % hgt) + hgt - 1) % hgt;
        left = ((c % wid) + wid - 1) % wid;
        return ((top + a) % hgt) * MAX_DIM + (left + b) % wid;
    endfunction

    function automatic t_pixel window_median(int r, int c);
        t_pixel vals[MAX_KERNEL*MAX_KERNEL];
        t_pixel key;
        int n, j;
        n = kern * kern;
        for (int a = 0; a < kern; a++)
            for (int b = 0; b < kern; b++)
                vals[a*kern+b] = img_mem[win_addr(r, c, a, b)];
        for (int i = 1; i < n; i++) begin
            key = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > key) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = key;
        end
        if (n % 2 == 1)
            return vals[n/2];
        return t_pixel'((int'(vals[n/2-1]) + int'(vals[n/2])) / 2);
    endfunction

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_BITS'(value);
        case (idx)
            CFG_KERNEL_SIZE:  kern = clamp(value & 7, 1, MAX_KERNEL);
            CFG_IMAGE_HEIGHT: hgt  = clamp(value & 'h1ff, 1, MAX_DIM);
            CFG_IMAGE_WIDTH:  wid  = clamp(value & 'h1ff, 1, MAX_DIM);
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one request and updates the shadow once it is taken.
    task automatic send_req(logic act, int r, int c, int p, bit typed, int typed_val);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_row         <= DIM_BITS'(r);
        i_column      <= DIM_BITS'(c);
        i_pixel_value <= PIX_BITS'(p);
        do @(posedge i_clk); while (o_stall);
        if (act == ACT_WRITE) begin
            img_mem[r*MAX_DIM+c]   = t_pixel'(p);
            img_known[r*MAX_DIM+c] = 1'b1;
            n_writes++;
        end else begin
            medians_due.push_back(typed ? t_pixel'(typed_val) : window_median(r, c));
            n_computes++;
        end
    endtask

    // Writes any pixel of the window that is still unknown, then asks for the median.
    task automatic request_median(int r, int c, bit typed, int typed_val);
        int ad;
        for (int a = 0; a < kern; a++)
            for (int b = 0; b < kern; b++) begin
                ad = win_addr(r, c, a, b);
                if (!img_known[ad])
                    send_req(ACT_WRITE, ad / MAX_DIM, ad % MAX_DIM, $urandom_range(255), 0, 0);
            end
        send_req(ACT_COMPUTE, r, c, $urandom_range(255), typed, typed_val);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (medians_due.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    typedef struct {
        logic act;
        int   r, c, p;
        bit   typed;
        int   val;
    } t_vec;

    t_vec dir_tab[] = '{
        '{ACT_WRITE, 0, 0, 255, 0, 0}, '{ACT_WRITE, 0, 1, 255, 0, 0},
        '{ACT_WRITE, 0, 2, 255, 0, 0}, '{ACT_WRITE, 1, 0, 255, 0, 0},
        '{ACT_WRITE, 1, 1, 255, 0, 0}, '{ACT_WRITE, 1, 2, 255, 0, 0},
        '{ACT_WRITE, 2, 0, 255, 0, 0}, '{ACT_WRITE, 2, 1, 255, 0, 0},
        '{ACT_WRITE, 2, 2, 255, 0, 0},
        '{ACT_COMPUTE, 1, 1, 0, 1, 255},
        '{ACT_WRITE, 1, 1, 0, 0, 0},
        '{ACT_COMPUTE, 1, 1, 255, 1, 255},
        '{ACT_WRITE, 0, 0, 0, 0, 0}, '{ACT_WRITE, 0, 1, 0, 0, 0},
        '{ACT_WRITE, 0, 2, 0, 0, 0}, '{ACT_WRITE, 2, 0, 0, 0, 0},
        '{ACT_COMPUTE, 1, 1, 0, 1, 0},
        '{ACT_WRITE, 255, 255, 'h5a, 0, 0}, '{ACT_WRITE, 128, 128, 'ha5, 0, 0},
        '{ACT_COMPUTE, 0, 0, 0, 0, 0},
        '{ACT_COMPUTE, 255, 255, 0, 0, 0},
        '{ACT_COMPUTE, 128, 128, 0, 0, 0}
    };

    // Filter settings per random phase: kernel, height, width (raw register values).
    int phase_cfg[][3] = '{
        '{1, 1, 1}, '{7, 1, 1}, '{0, 5, 3}, '{2, 8, 8}, '{7, 12, 12},
        '{4, 511, 0}, '{6, 13, 9}, '{5, 16, 16}, '{3, 256, 256}
    };

    always @(negedge i_clk) begin
        if (hold_req) begin
            i_stall <= 1'b1;
            repeat (400) @(negedge i_clk);
            hold_req = 1'b0;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("tb_wrapped_window_median_filter: done, errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (medians_due.size() == 0) begin
                $display("%0t: unexpected result %0d", $realtime, o_median_value);
                errors++;
            end else begin
                if (o_median_value !== medians_due[0]) begin
                    $display("%0t: median expected %0d actual %0d",
                             $realtime, medians_due[0], o_median_value);
                    errors++;
                end
                void'(medians_due.pop_front());
                n_checked++;
            end
        end
    end

    initial begin
        int r, c, span;
        kern = 3;
        hgt  = MAX_DIM;
        wid  = MAX_DIM;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].act == ACT_COMPUTE)
                request_median(dir_tab[i].r, dir_tab[i].c, dir_tab[i].typed, dir_tab[i].val);
            else
                send_req(ACT_WRITE, dir_tab[i].r, dir_tab[i].c, dir_tab[i].p, 0, 0);
        end
        drain();

        foreach (phase_cfg[ph]) begin
            cfg_write(CFG_KERNEL_SIZE, phase_cfg[ph][0]);
            cfg_write(CFG_IMAGE_HEIGHT, phase_cfg[ph][1]);
            cfg_write(CFG_IMAGE_WIDTH, phase_cfg[ph][2]);
            if (ph == 2)
                cfg_write(CFG_BAD_INDEX, 'h1ff);
            cfg_done();
            quiet = (ph == 3);
            if (ph == 6)
                hold_req = 1'b1;
            span = (hgt < 16 ? hgt : 16);
            for (int n = 0; n < 75; n++) begin
                r = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(span + 1);
                c = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(span + 1);
                if ($urandom_range(1))
                    request_median(r, c, 0, 0);
                else
                    send_req(ACT_WRITE, r, c,
                             $urandom_range(3) == 0 ? 16 * $urandom_range(2) : $urandom_range(255),
                             0, 0);
            end
            drain();
        end
        quiet = 1'b0;

        $display("Covered %0d pixel writes and %0d median requests over %0d filter settings;",
                 n_writes, n_computes, phase_cfg.size() + 1);
        $display("%0d medians compared, %0d mismatches.", n_checked, errors);
        if (errors == 0)
            $display("tb_wrapped_window_median_filter: done, clean");
        else
            $display("tb_wrapped_window_median_filter: done, errors");
        $finish;
    end

endmodule
